@@ sv/bertlv_pkg.sv @@
// Shared types, constants and helpers for the BER-TLV tag search block.
// No dependencies; imported by bertlv_stack, bertlv_parser and ber_tlv_tag_search.
package bertlv_pkg;

    localparam int BT_MAX_DEPTH = 4;
    localparam int BT_POS_BITS  = 16;

    localparam logic [15:0] TAG_FCI      = 16'h006F;
    localparam logic [15:0] TAG_FCI_PROP = 16'h00A5;
    localparam logic [15:0] TAG_RSP_FMT2 = 16'h0077;
    localparam logic [15:0] TAG_REC      = 16'h0070;
    localparam logic [15:0] TAG_APP      = 16'h0061;
    localparam logic [15:0] TAG_FCI_DISC = 16'hBF0C;

    localparam logic [4:0] TAG_MULTI_MASK = 5'h1F;

    typedef enum logic [2:0] {
        PH_TAG1  = 3'd0,
        PH_TAG2  = 3'd1,
        PH_LEN1  = 3'd2,
        PH_LENX  = 3'd3,
        PH_SKIP  = 3'd4,
        PH_MATCH = 3'd5,
        PH_DONE  = 3'd6
    } t_phase;

    function automatic logic is_template(input logic [15:0] tag);
        is_template = (tag == TAG_FCI) || (tag == TAG_FCI_PROP) || (tag == TAG_RSP_FMT2) ||
                      (tag == TAG_REC) || (tag == TAG_APP) || (tag == TAG_FCI_DISC);
    endfunction

endpackage

@@ sv/bertlv_stack.sv @@
// Stack of open template end positions, with parallel compares against the next position.
// Depends on bertlv_pkg. The depth counter itself lives in bertlv_parser.
module bertlv_stack
    import bertlv_pkg::*;
#(
    parameter int MAX_DEPTH = BT_MAX_DEPTH,
    parameter int POS_BITS  = BT_POS_BITS,
    localparam int PW    = POS_BITS + 1,
    localparam int DEP_W = $clog2(MAX_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [DEP_W-1:0] i_depth,
    input  logic [PW-1:0]    i_wr_data,
    input  logic [PW-1:0]    i_nxt,
    output logic [PW-1:0]    o_top_end,
    output logic [DEP_W-1:0] o_keep_cnt,
    output logic [DEP_W-1:0] o_keep_err
);

    logic [PW-1:0] r_entries [MAX_DEPTH];

    // push writes at the current depth
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if (i_wr_en && (i_depth == DEP_W'(i))) begin
                r_entries[i] <= i_wr_data;
            end
        end
    end

    // Ends are non-increasing toward the top, so the entries still open after
    // position i_nxt form a prefix and their count is the new depth.
    always_comb begin
        o_top_end  = '0;
        o_keep_cnt = '0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if (i_depth == DEP_W'(i + 1)) begin
                o_top_end = r_entries[i];
            end
            if ((DEP_W'(i) < i_depth) && (r_entries[i] > i_nxt)) begin
                o_keep_cnt = o_keep_cnt + DEP_W'(1);
            end
        end
        if (i_depth == '0) begin
            o_keep_err = '0;
        end else if (o_keep_cnt == i_depth) begin
            o_keep_err = i_depth - DEP_W'(1);
        end else begin
            o_keep_err = o_keep_cnt;
        end
    end

endmodule

@@ sv/bertlv_parser.sv @@
// One-byte-per-step TLV parser: header decode, template descent, match tracking.
// Depends on bertlv_pkg and bertlv_stack.
module bertlv_parser
    import bertlv_pkg::*;
#(
    parameter int MAX_DEPTH = BT_MAX_DEPTH,
    parameter int POS_BITS  = BT_POS_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    input  logic [15:0] i_search_tag,
    output logic [7:0]  o_value_byte,
    output logic        o_value_valid,
    output logic        o_done_res,
    output logic        o_found
);

    localparam int PW    = POS_BITS + 1;
    localparam int DEP_W = $clog2(MAX_DEPTH + 1);
    localparam logic [PW-1:0] POS_LIMIT = {1'b1, {POS_BITS{1'b0}}};

    t_phase              r_phase, n_phase;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [15:0]         r_tag, n_tag;
    logic [PW-1:0]       r_len, n_len;
    logic [6:0]          r_left, n_left;
    logic [PW-1:0]       r_elem_end, n_elem_end;
    logic [DEP_W-1:0]    r_depth, n_depth;
    logic                r_match, n_match;
    logic [PW-1:0]       r_top_end, n_top_end;

    logic [PW-1:0]    nxt;
    logic [PW-1:0]    top_end;
    logic [DEP_W-1:0] keep_cnt;
    logic [DEP_W-1:0] keep_err;
    logic             push;

    logic [PW+7:0]    len_shift;
    logic [PW-1:0]    len_val;
    logic [PW:0]      hdr_sum;
    logic [PW-1:0]    hdr_end;
    logic             do_hdr, do_perr, do_chk, do_fin, do_err, hdr_bad;
    logic [6:0]       left_dec;

    assign nxt = {1'b0, r_pos} + PW'(1);

    bertlv_stack #(
        .MAX_DEPTH (MAX_DEPTH),
        .POS_BITS  (POS_BITS)
    ) u_stack (
        .i_clk      (i_clk),
        .i_wr_en    (push),
        .i_depth    (r_depth),
        .i_wr_data  (hdr_end),
        .i_nxt      (nxt),
        .o_top_end  (top_end),
        .o_keep_cnt (keep_cnt),
        .o_keep_err (keep_err)
    );

    // length arithmetic, saturating at 2^POS_BITS
    always_comb begin
        len_shift = {r_len, i_data_byte};
        if (r_phase == PH_LENX) begin
            len_val = (|len_shift[PW+7:POS_BITS]) ? POS_LIMIT : len_shift[PW-1:0];
        end else begin
            len_val = PW'(i_data_byte);
        end
        hdr_sum = {1'b0, nxt} + {1'b0, len_val};
        hdr_end = (hdr_sum > (PW+1)'(POS_LIMIT)) ? POS_LIMIT : hdr_sum[PW-1:0];
        left_dec = (r_left != '0) ? (r_left - 7'd1) : '0;
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_tag      = r_tag;
        n_len      = r_len;
        n_left     = r_left;
        n_elem_end = r_elem_end;
        n_depth    = r_depth;
        n_match    = r_match;
        n_top_end  = r_top_end;
        do_hdr     = 1'b0;
        do_perr    = 1'b0;
        do_chk     = 1'b0;
        do_fin     = 1'b0;
        push       = 1'b0;

        unique case (r_phase)
            PH_TAG1: begin
                n_tag   = {8'h00, i_data_byte};
                n_phase = (i_data_byte[4:0] == TAG_MULTI_MASK) ? PH_TAG2 : PH_LEN1;
                do_chk  = 1'b1;
            end
            PH_TAG2: begin
                n_tag   = {r_tag[7:0], i_data_byte};
                n_phase = PH_LEN1;
                do_chk  = 1'b1;
            end
            PH_LEN1: begin
                if (i_data_byte[7]) begin
                    if (i_data_byte[6:0] == 7'd0) begin
                        do_perr = 1'b1;
                    end else begin
                        n_left  = i_data_byte[6:0];
                        n_len   = '0;
                        n_phase = PH_LENX;
                        do_chk  = 1'b1;
                    end
                end else begin
                    n_len  = len_val;
                    do_hdr = 1'b1;
                end
            end
            PH_LENX: begin
                n_len  = len_val;
                n_left = left_dec;
                if (left_dec == '0) begin
                    do_hdr = 1'b1;
                end else begin
                    do_chk = 1'b1;
                end
            end
            PH_SKIP: begin
                do_fin = (nxt >= r_elem_end);
            end
            PH_MATCH: begin
                if (nxt >= r_elem_end) begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        hdr_bad = do_hdr && (r_depth != '0) && (hdr_end > top_end);
        do_err  = ((do_perr || hdr_bad) && (r_depth != '0)) ||
                  (do_chk && (r_depth != '0) && (nxt >= top_end));

        if (do_perr && (r_depth == '0)) begin
            n_phase = PH_DONE;
            n_match = 1'b0;
        end

        if (do_hdr && !hdr_bad) begin
            if (r_depth == '0) begin
                n_top_end = hdr_end;
            end
            if (r_tag == i_search_tag) begin
                n_match    = 1'b1;
                n_elem_end = hdr_end;
                n_phase    = (len_val == '0) ? PH_DONE : PH_MATCH;
            end else if ((len_val != '0) && is_template(r_tag) &&
                         (r_depth < DEP_W'(MAX_DEPTH))) begin
                push    = i_step;
                n_depth = r_depth + DEP_W'(1);
                n_phase = PH_TAG1;
            end else if (len_val == '0) begin
                do_fin = 1'b1;
            end else begin
                n_elem_end = hdr_end;
                n_phase    = PH_SKIP;
            end
        end

        // skip the rest of the innermost template
        if (do_err) begin
            n_depth = keep_err;
            if (nxt >= top_end) begin
                n_phase = PH_TAG1;
            end else begin
                n_elem_end = top_end;
                n_phase    = PH_SKIP;
            end
        end

        if (do_fin) begin
            n_phase = PH_TAG1;
            n_depth = keep_cnt;
        end

        n_pos = nxt[POS_BITS] ? '1 : nxt[POS_BITS-1:0];
    end

    // result of this byte
    always_comb begin
        o_value_valid = (r_phase == PH_MATCH);
        o_value_byte  = o_value_valid ? i_data_byte : 8'h00;
        o_done_res    = i_last;
        o_found       = i_last && n_match && (n_top_end <= nxt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TAG1;
            r_pos      <= '0;
            r_tag      <= '0;
            r_len      <= '0;
            r_left     <= '0;
            r_elem_end <= '0;
            r_depth    <= '0;
            r_match    <= 1'b0;
            r_top_end  <= '0;
        end else if (i_step) begin
            if (i_last) begin
                r_phase    <= PH_TAG1;
                r_pos      <= '0;
                r_tag      <= '0;
                r_len      <= '0;
                r_left     <= '0;
                r_elem_end <= '0;
                r_depth    <= '0;
                r_match    <= 1'b0;
                r_top_end  <= '0;
            end else begin
                r_phase    <= n_phase;
                r_pos      <= n_pos;
                r_tag      <= n_tag;
                r_len      <= n_len;
                r_left     <= n_left;
                r_elem_end <= n_elem_end;
                r_depth    <= n_depth;
                r_match    <= n_match;
                r_top_end  <= n_top_end;
            end
        end
    end

endmodule

@@ sv/ber_tlv_tag_search.sv @@
// BER-TLV tag search, top level: stream ports, search tag register, input and result registers.
// Depends on bertlv_pkg and bertlv_parser.
//
// Takes one byte per cycle while the output is not stalled and returns exactly one result
// per byte, registered in the input register and then the result register. Throughput is
// one byte per clock while the output is not stalled: the parser step from the input register
// to the result register is combinational (header decode, end-position add and compare,
// template stack update), and the result register lets a new byte enter while a result waits.
// The value bytes of the first element carrying the search tag come out with
// tuser[0] set; the result for the tlast byte carries tlast and, in tuser[1],
// whether the match was complete inside the buffer. The search tag may be
// written only while no transfer is in flight.
module ber_tlv_tag_search
    import bertlv_pkg::*;
#(
    parameter int MAX_DEPTH = BT_MAX_DEPTH,
    parameter int POS_BITS  = BT_POS_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,      // search_tag
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] value_byte
    output logic [1:0]  o_m_axis_tuser,   // [0] value_valid, [1] found
    output logic        o_m_axis_tlast    // done_res
);

    logic [15:0] r_search_tag;
    logic        r_in_valid;
    logic [7:0]  r_in_data;
    logic        r_in_last;
    logic        r_out_valid;
    logic [7:0]  r_out_data;
    logic [1:0]  r_out_user;
    logic        r_out_last;

    logic        advance;
    logic [7:0]  p_value_byte;
    logic        p_value_valid;
    logic        p_done;
    logic        p_found;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_tag <= '0;
        end else if (i_cfg_we) begin
            r_search_tag <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    bertlv_parser #(
        .MAX_DEPTH (MAX_DEPTH),
        .POS_BITS  (POS_BITS)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_data_byte   (r_in_data),
        .i_last        (r_in_last),
        .i_search_tag  (r_search_tag),
        .o_value_byte  (p_value_byte),
        .o_value_valid (p_value_valid),
        .o_done_res    (p_done),
        .o_found       (p_found)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= p_value_byte;
            r_out_user <= {p_found, p_value_valid};
            r_out_last <= p_done;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;

    // found is only reported on the final transfer of a buffer
    a_found_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> o_m_axis_tlast)
        else $error("found set on a result that is not the last");

    // bytes outside the matched value are zeroed
    a_value_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == 8'h00))
        else $error("value byte nonzero outside the match");

    // a held input byte is not consumed or overwritten while the output stalls
    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_data) && $stable(r_in_last)))
        else $error("input register lost a byte during a stall");

endmodule
